// ===== sv/lav_pkg.sv =====
package lav_pkg;

    typedef logic signed [31:0] w32_t;
    typedef logic signed [63:0] w64_t;
    typedef logic signed [65:0] w66_t;
    typedef w32_t [2:0] vec32_t;
    typedef w64_t [2:0] vec64_t;

    // Q2.30 fraction bits, number of sqrt and divide steps
    localparam int FRAC_BITS  = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    // values that ride along with a vector through the long units
    typedef struct packed {
        vec32_t eye;
        vec32_t fwd;
        vec32_t sid;
    } lav_side_t;

    // per-item state inside the normalizer after the alignment shift
    typedef struct packed {
        logic [2:0][30:0] q;
        logic [2:0]       neg;
        logic             zero;
        lav_side_t        side;
    } lav_carry_t;

    // round to nearest by 2^30, ties away from zero
    function automatic w66_t round_q30(input w66_t x);
        logic [65:0] mag;
        logic [65:0] m;
        mag = x[65] ? (~x + 66'd1) : x;
        m = (mag + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return x[65] ? w66_t'(~m + 66'd1) : w66_t'(m);
    endfunction

endpackage

// ===== sv/lav_cross.sv =====
module lav_cross (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  lav_pkg::vec32_t     a,
    input  lav_pkg::vec32_t     b,
    input  lav_pkg::lav_side_t  side_in,
    output logic                out_vld,
    output lav_pkg::vec64_t     c,
    output lav_pkg::lav_side_t  side_out
);
    import lav_pkg::*;

    logic      p_vld_reg;
    w64_t      p_reg [6];
    lav_side_t p_side_reg;
    logic      c_vld_reg;
    vec64_t    c_reg;
    lav_side_t c_side_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_vld_reg <= in_vld;
            c_vld_reg <= p_vld_reg;
        end
    end

    // six products, then three differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0]   <= $signed(a[1]) * $signed(b[2]);
            p_reg[1]   <= $signed(a[2]) * $signed(b[1]);
            p_reg[2]   <= $signed(a[2]) * $signed(b[0]);
            p_reg[3]   <= $signed(a[0]) * $signed(b[2]);
            p_reg[4]   <= $signed(a[0]) * $signed(b[1]);
            p_reg[5]   <= $signed(a[1]) * $signed(b[0]);
            p_side_reg <= side_in;
            c_reg[0]   <= p_reg[0] - p_reg[1];
            c_reg[1]   <= p_reg[2] - p_reg[3];
            c_reg[2]   <= p_reg[4] - p_reg[5];
            c_side_reg <= p_side_reg;
        end
    end

    assign out_vld  = c_vld_reg;
    assign c        = c_reg;
    assign side_out = c_side_reg;

endmodule

// ===== sv/lav_norm.sv =====
module lav_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  lav_pkg::vec64_t     vin,
    input  lav_pkg::lav_side_t  side_in,
    output logic                out_vld,
    output lav_pkg::vec32_t     vout,
    output lav_pkg::lav_side_t  side_out
);
    import lav_pkg::*;

    function automatic logic [4:0] clz16(input logic [15:0] v);
        logic [4:0] n;
        logic       hit;
        n = 5'd0;
        hit = 1'b0;
        for (int k = 15; k >= 0; k--)
        begin
            if (!hit)
            begin
                if (v[k])
                    hit = 1'b1;
                else
                    n = n + 5'd1;
            end
        end
        return n;
    endfunction

    // stage 1: magnitudes and their or
    logic        s1_vld_reg;
    logic [63:0] s1_mag_reg [3];
    logic [2:0]  s1_neg_reg;
    logic [63:0] s1_or_reg;
    lav_side_t   s1_side_reg;
    logic [63:0] mag_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag_next[i] = vin[i][63] ? (~vin[i] + 64'd1) : vin[i];
    end

    // stage 2: leading zeros per 16-bit chunk
    logic        s2_vld_reg;
    logic [63:0] s2_mag_reg [3];
    logic [2:0]  s2_neg_reg;
    logic [4:0]  s2_clz_reg [4];
    lav_side_t   s2_side_reg;

    // stage 3: shift direction and amount
    logic        s3_vld_reg;
    logic [63:0] s3_mag_reg [3];
    logic [2:0]  s3_neg_reg;
    logic        s3_zero_reg;
    logic        s3_shr_reg;
    logic [4:0]  s3_amt_reg;
    lav_side_t   s3_side_reg;
    logic [6:0]  lz_next;
    logic [6:0]  amt_next;

    always_comb
    begin
        if (s2_clz_reg[3] != 5'd16)
            lz_next = {2'd0, s2_clz_reg[3]};
        else if (s2_clz_reg[2] != 5'd16)
            lz_next = 7'd16 + {2'd0, s2_clz_reg[2]};
        else if (s2_clz_reg[1] != 5'd16)
            lz_next = 7'd32 + {2'd0, s2_clz_reg[1]};
        else
            lz_next = 7'd48 + {2'd0, s2_clz_reg[0]};
        amt_next = (lz_next < 7'd33) ? (7'd33 - lz_next) : (lz_next - 7'd33);
    end

    // stage 4: aligned magnitudes, stage 5: squares, stage 6: sum
    logic       s4_vld_reg;
    lav_carry_t s4_c_reg;
    logic       s5_vld_reg;
    lav_carry_t s5_c_reg;
    logic [61:0] s5_sq_reg [3];
    logic       s6_vld_reg;
    lav_carry_t s6_c_reg;
    logic [63:0] s6_sum_reg;
    lav_carry_t c4_next;
    logic [63:0] sh_next [3];

    always_comb
    begin
        c4_next.neg  = s3_neg_reg;
        c4_next.zero = s3_zero_reg;
        c4_next.side = s3_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            sh_next[i] = s3_shr_reg ? (s3_mag_reg[i] >> s3_amt_reg)
                                    : (s3_mag_reg[i] << s3_amt_reg);
            c4_next.q[i] = sh_next[i][30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_mag_reg[i] <= mag_next[i];
                s2_mag_reg[i] <= s1_mag_reg[i];
                s3_mag_reg[i] <= s2_mag_reg[i];
                s1_neg_reg[i] <= vin[i][63];
                s5_sq_reg[i]  <= 62'(s4_c_reg.q[i]) * 62'(s4_c_reg.q[i]);
            end
            s1_or_reg   <= mag_next[0] | mag_next[1] | mag_next[2];
            s1_side_reg <= side_in;
            for (int j = 0; j < 4; j++)
                s2_clz_reg[j] <= clz16(s1_or_reg[j*16 +: 16]);
            s2_neg_reg  <= s1_neg_reg;
            s2_side_reg <= s1_side_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_side_reg <= s2_side_reg;
            s3_zero_reg <= (lz_next == 7'd64);
            s3_shr_reg  <= (lz_next < 7'd33);
            s3_amt_reg  <= amt_next[4:0];
            s4_c_reg    <= c4_next;
            s5_c_reg    <= s4_c_reg;
            s6_c_reg    <= s5_c_reg;
            s6_sum_reg  <= {2'd0, s5_sq_reg[0]} + {2'd0, s5_sq_reg[1]}
                         + {2'd0, s5_sq_reg[2]};
        end
    end

    // integer square root, one result bit per stage
    logic [63:0] sx_reg [SQRT_STEPS];
    logic [63:0] sr_reg [SQRT_STEPS];
    logic        sv_reg [SQRT_STEPS];
    lav_carry_t  sc_reg [SQRT_STEPS];
    logic [63:0] sxi [SQRT_STEPS];
    logic [63:0] sri [SQRT_STEPS];
    logic        svi [SQRT_STEPS];
    lav_carry_t  sci [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int SH = 62 - 2 * k;
        localparam logic [63:0] BITK = 64'd1 << SH;
        logic [63:0] trial;
        logic [63:0] x_next;
        logic [63:0] r_next;

        if (k == 0)
        begin : g_first
            assign sxi[k] = s6_sum_reg;
            assign sri[k] = 64'd0;
            assign svi[k] = s6_vld_reg;
            assign sci[k] = s6_c_reg;
        end
        else
        begin : g_next
            assign sxi[k] = sx_reg[k-1];
            assign sri[k] = sr_reg[k-1];
            assign svi[k] = sv_reg[k-1];
            assign sci[k] = sc_reg[k-1];
        end

        always_comb
        begin
            trial = sri[k] + BITK;
            if (sxi[k] >= trial)
            begin
                x_next = sxi[k] - trial;
                r_next = (sri[k] >> 1) + BITK;
            end
            else
            begin
                x_next = sxi[k];
                r_next = sri[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k] <= 1'b0;
            else if (adv)
                sv_reg[k] <= svi[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sx_reg[k] <= x_next;
                sr_reg[k] <= r_next;
                sc_reg[k] <= sci[k];
            end
        end
    end

    // numerators q * 2^30 + len / 2
    logic        nm_vld_reg;
    logic [63:0] nm_num_reg [3];
    logic [31:0] nm_len_reg;
    lav_carry_t  nm_c_reg;
    logic [31:0] len_w;

    assign len_w = sr_reg[SQRT_STEPS-1][31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nm_vld_reg <= 1'b0;
        else if (adv)
            nm_vld_reg <= sv_reg[SQRT_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                nm_num_reg[i] <= {3'd0, sc_reg[SQRT_STEPS-1].q[i], 30'd0}
                               + {33'd0, len_w[31:1]};
            nm_len_reg <= len_w;
            nm_c_reg   <= sc_reg[SQRT_STEPS-1];
        end
    end

    // restoring division, one quotient bit per stage for all three parts
    logic [63:0] drm_reg [DIV_STEPS][3];
    logic [30:0] dqo_reg [DIV_STEPS][3];
    logic [31:0] dl_reg  [DIV_STEPS];
    logic        dv_reg  [DIV_STEPS];
    lav_carry_t  dc_reg  [DIV_STEPS];
    logic [63:0] drmi [DIV_STEPS][3];
    logic [30:0] dqoi [DIV_STEPS][3];
    logic [31:0] dli  [DIV_STEPS];
    logic        dvi  [DIV_STEPS];
    lav_carry_t  dci  [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int P = DIV_STEPS - 1 - j;
        logic [63:0] den;
        logic [63:0] rm_next [3];
        logic [30:0] qo_next [3];

        if (j == 0)
        begin : g_first
            for (genvar i = 0; i < 3; i++)
            begin : g_in
                assign drmi[j][i] = nm_num_reg[i];
                assign dqoi[j][i] = 31'd0;
            end
            assign dli[j] = nm_len_reg;
            assign dvi[j] = nm_vld_reg;
            assign dci[j] = nm_c_reg;
        end
        else
        begin : g_next
            for (genvar i = 0; i < 3; i++)
            begin : g_in
                assign drmi[j][i] = drm_reg[j-1][i];
                assign dqoi[j][i] = dqo_reg[j-1][i];
            end
            assign dli[j] = dl_reg[j-1];
            assign dvi[j] = dv_reg[j-1];
            assign dci[j] = dc_reg[j-1];
        end

        always_comb
        begin
            den = {32'd0, dli[j]} << P;
            for (int i = 0; i < 3; i++)
            begin
                if (drmi[j][i] >= den)
                begin
                    rm_next[i] = drmi[j][i] - den;
                    qo_next[i] = dqoi[j][i] | (31'd1 << P);
                end
                else
                begin
                    rm_next[i] = drmi[j][i];
                    qo_next[i] = dqoi[j][i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j] <= 1'b0;
            else if (adv)
                dv_reg[j] <= dvi[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drm_reg[j][i] <= rm_next[i];
                    dqo_reg[j][i] <= qo_next[i];
                end
                dl_reg[j] <= dli[j];
                dc_reg[j] <= dci[j];
            end
        end
    end

    // sign and zero-length override
    logic       o_vld_reg;
    vec32_t     o_v_reg;
    lav_side_t  o_side_reg;
    lav_carry_t dlast;
    logic [31:0] qext [3];

    assign dlast = dc_reg[DIV_STEPS-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            qext[i] = {1'b0, dqo_reg[DIV_STEPS-1][i]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (adv)
            o_vld_reg <= dv_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dlast.zero)
                    o_v_reg[i] <= '0;
                else if (dlast.neg[i])
                    o_v_reg[i] <= ~qext[i] + 32'd1;
                else
                    o_v_reg[i] <= qext[i];
            end
            o_side_reg <= dlast.side;
        end
    end

    assign out_vld  = o_vld_reg;
    assign vout     = o_v_reg;
    assign side_out = o_side_reg;

endmodule

// ===== sv/look_at_view_matrix.sv =====
// channel | signals                                   | handshake
// --------+-------------------------------------------+--------------------------
// input   | eye_*, target_*, up_* (Q16.16)            | in_valid / in_stall
// output  | side_*, trueup_*, back_* (Q2.30),         | out_valid / out_stall
//         | shift_side, shift_up, shift_fwd (Q32.16)  |
//
// one beat enters per cycle while in_stall is low
// the path runs through two normalizers in series, each a 32-step square root
// followed by a 31-step divider, one step per stage
// rst_n clears all valid bits asynchronously; no other state is kept
// out_stall with a waiting result freezes the whole pipeline and raises in_stall
module look_at_view_matrix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  eye_x,
    input  logic signed [31:0]  eye_y,
    input  logic signed [31:0]  eye_z,
    input  logic signed [31:0]  target_x,
    input  logic signed [31:0]  target_y,
    input  logic signed [31:0]  target_z,
    input  logic signed [31:0]  up_x,
    input  logic signed [31:0]  up_y,
    input  logic signed [31:0]  up_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  side_x,
    output logic signed [31:0]  side_y,
    output logic signed [31:0]  side_z,
    output logic signed [31:0]  trueup_x,
    output logic signed [31:0]  trueup_y,
    output logic signed [31:0]  trueup_z,
    output logic signed [31:0]  back_x,
    output logic signed [31:0]  back_y,
    output logic signed [31:0]  back_z,
    output logic signed [47:0]  shift_side,
    output logic signed [47:0]  shift_up,
    output logic signed [47:0]  shift_fwd
);
    import lav_pkg::*;

    logic adv;

    // whole pipeline moves unless a finished beat is held
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // input register: eye, target minus eye, up hint
    logic   i_vld_reg;
    vec32_t i_eye_reg;
    vec64_t i_d_reg;
    vec64_t i_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_vld_reg <= 1'b0;
        else if (adv)
            i_vld_reg <= in_valid && !in_stall;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_eye_reg[0] <= eye_x;
            i_eye_reg[1] <= eye_y;
            i_eye_reg[2] <= eye_z;
            i_d_reg[0]   <= 64'(target_x) - 64'(eye_x);
            i_d_reg[1]   <= 64'(target_y) - 64'(eye_y);
            i_d_reg[2]   <= 64'(target_z) - 64'(eye_z);
            i_up_reg[0]  <= 64'(up_x);
            i_up_reg[1]  <= 64'(up_y);
            i_up_reg[2]  <= 64'(up_z);
        end
    end

    // forward and up normalized side by side
    lav_side_t nf_side_in;
    logic      nf_vld;
    vec32_t    nf_v;
    lav_side_t nf_side;
    vec32_t    nu_v;

    always_comb
    begin
        nf_side_in     = '0;
        nf_side_in.eye = i_eye_reg;
    end

    lav_norm u_norm_f (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (i_vld_reg),
        .vin      (i_d_reg),
        .side_in  (nf_side_in),
        .out_vld  (nf_vld),
        .vout     (nf_v),
        .side_out (nf_side)
    );

    lav_norm u_norm_u (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (i_vld_reg),
        .vin      (i_up_reg),
        .side_in  ('0),
        .out_vld  (),
        .vout     (nu_v),
        .side_out ()
    );

    // forward cross up
    lav_side_t c1_side_in;
    logic      c1_vld;
    vec64_t    c1_v;
    lav_side_t c1_side;

    always_comb
    begin
        c1_side_in     = '0;
        c1_side_in.eye = nf_side.eye;
        c1_side_in.fwd = nf_v;
    end

    lav_cross u_cross_fu (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (nf_vld),
        .a        (nf_v),
        .b        (nu_v),
        .side_in  (c1_side_in),
        .out_vld  (c1_vld),
        .c        (c1_v),
        .side_out (c1_side)
    );

    // side vector
    logic      ns_vld;
    vec32_t    ns_v;
    lav_side_t ns_side;

    lav_norm u_norm_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (c1_vld),
        .vin      (c1_v),
        .side_in  (c1_side),
        .out_vld  (ns_vld),
        .vout     (ns_v),
        .side_out (ns_side)
    );

    // side cross forward
    lav_side_t c2_side_in;
    logic      c2_vld;
    vec64_t    c2_v;
    lav_side_t c2_side;

    always_comb
    begin
        c2_side_in     = ns_side;
        c2_side_in.sid = ns_v;
    end

    lav_cross u_cross_sf (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (ns_vld),
        .a        (ns_v),
        .b        (ns_side.fwd),
        .side_in  (c2_side_in),
        .out_vld  (c2_vld),
        .c        (c2_v),
        .side_out (c2_side)
    );

    // true up rounded to Q2.30
    logic      r_vld_reg;
    vec32_t    r_t_reg;
    lav_side_t r_side_reg;
    w66_t      rt_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            rt_next[i] = round_q30(66'(c2_v[i]));
    end

    // dot product terms
    logic      p_vld_reg;
    vec32_t    p_t_reg;
    lav_side_t p_side_reg;
    vec64_t    p_s_reg;
    vec64_t    p_u_reg;
    vec64_t    p_f_reg;

    // dot sums
    logic      d_vld_reg;
    vec32_t    d_t_reg;
    lav_side_t d_side_reg;
    w66_t      d_s_reg;
    w66_t      d_u_reg;
    w66_t      d_f_reg;

    // output register
    logic      o_vld_reg;
    vec32_t    o_s_reg;
    vec32_t    o_t_reg;
    vec32_t    o_b_reg;
    logic [47:0] o_ss_reg;
    logic [47:0] o_su_reg;
    logic [47:0] o_sf_reg;
    w66_t      rs_next;
    w66_t      ru_next;
    w66_t      rf_next;

    always_comb
    begin
        rs_next = round_q30(d_s_reg);
        ru_next = round_q30(d_u_reg);
        rf_next = round_q30(d_f_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_vld_reg <= c2_vld;
            p_vld_reg <= r_vld_reg;
            d_vld_reg <= p_vld_reg;
            o_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r_t_reg[i] <= rt_next[i][31:0];
                p_s_reg[i] <= $signed(r_side_reg.sid[i]) * $signed(r_side_reg.eye[i]);
                p_u_reg[i] <= $signed(r_t_reg[i]) * $signed(r_side_reg.eye[i]);
                p_f_reg[i] <= $signed(r_side_reg.fwd[i]) * $signed(r_side_reg.eye[i]);
                o_b_reg[i] <= ~d_side_reg.fwd[i] + 32'd1;
            end
            r_side_reg <= c2_side;
            p_t_reg    <= r_t_reg;
            p_side_reg <= r_side_reg;
            d_s_reg    <= 66'(p_s_reg[0]) + 66'(p_s_reg[1]) + 66'(p_s_reg[2]);
            d_u_reg    <= 66'(p_u_reg[0]) + 66'(p_u_reg[1]) + 66'(p_u_reg[2]);
            d_f_reg    <= 66'(p_f_reg[0]) + 66'(p_f_reg[1]) + 66'(p_f_reg[2]);
            d_t_reg    <= p_t_reg;
            d_side_reg <= p_side_reg;
            o_s_reg    <= d_side_reg.sid;
            o_t_reg    <= d_t_reg;
            o_ss_reg   <= 48'(~rs_next + 66'd1);
            o_su_reg   <= 48'(~ru_next + 66'd1);
            o_sf_reg   <= rf_next[47:0];
        end
    end

    assign out_valid  = o_vld_reg;
    assign side_x     = o_s_reg[0];
    assign side_y     = o_s_reg[1];
    assign side_z     = o_s_reg[2];
    assign trueup_x   = o_t_reg[0];
    assign trueup_y   = o_t_reg[1];
    assign trueup_z   = o_t_reg[2];
    assign back_x     = o_b_reg[0];
    assign back_y     = o_b_reg[1];
    assign back_z     = o_b_reg[2];
    assign shift_side = o_ss_reg;
    assign shift_up   = o_su_reg;
    assign shift_fwd  = o_sf_reg;

endmodule
